### rtl/button_gesture_classifier_defines.svh
// Assertion macros shared by the button gesture classifier RTL.
// No dependencies; included by the modules that carry concurrent assertions.
`ifndef BUTTON_GESTURE_CLASSIFIER_DEFINES_SVH
`define BUTTON_GESTURE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BGC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BGC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bgc_pkg.sv
// Shared types and constants for the button gesture classifier.
// No dependencies; used by bgc_core and button_gesture_classifier.
package bgc_pkg;

    // Default counter width and reset values of the configuration registers.
    localparam int unsigned COUNT_BITS_DEF = 16;
    localparam int unsigned CFG_W          = 16;
    localparam logic [CFG_W-1:0] DEBOUNCE_DEF = 16'd50;
    localparam logic [CFG_W-1:0] WINDOW_DEF   = 16'd1000;
    localparam logic [CFG_W-1:0] LONG_DEF     = 16'd5000;

    // Configuration register indexes.
    localparam int unsigned CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG     = 2'd2;

    // Gesture codes.
    typedef enum logic [1:0] {
        GEST_NONE   = 2'd0,
        GEST_DOUBLE = 2'd1,
        GEST_LONG   = 2'd2,
        GEST_SINGLE = 2'd3
    } t_gesture;

    // Thresholds handed to the tick logic.
    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] double_window_ticks;
        logic [CFG_W-1:0] long_press_ticks;
    } t_bgc_cfg;

    // One tick's result.
    typedef struct packed {
        t_gesture gesture_now;
        t_gesture latched_gesture;
        logic     power_on;
    } t_bgc_result;

endpackage

### rtl/bgc_core.sv
// Tick logic of the button gesture classifier: counters, click and hold state.
// Depends on bgc_pkg and button_gesture_classifier_defines.svh.
`include "button_gesture_classifier_defines.svh"

module bgc_core #(
    parameter int unsigned COUNT_BITS = bgc_pkg::COUNT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_level,
    input  logic                 i_read_clear,
    input  bgc_pkg::t_bgc_cfg    i_cfg,
    output bgc_pkg::t_bgc_result o_result
);
    import bgc_pkg::*;

    // Compare width covers both the counters and the thresholds.
    localparam int unsigned CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

    logic                  r_prev_level,    n_prev_level;
    logic [COUNT_BITS-1:0] r_since_change,  n_since_change;
    logic [COUNT_BITS-1:0] r_since_click,   n_since_click;
    logic                  r_click_pending, n_click_pending;
    logic                  r_long_done,     n_long_done;
    t_gesture              r_latch,         n_latch;
    logic                  r_power_flag,    n_power_flag;

    logic [COUNT_BITS-1:0] inc_change, inc_click;
    logic [CMP_W-1:0]      change_ext, click_ext;
    logic [CMP_W-1:0]      deb_ext, win_ext, long_ext;
    t_gesture              gesture, seen;

    // Saturating increments and widened operands for the threshold compares.
    always_comb begin
        inc_change = (r_since_change == '1) ? r_since_change : r_since_change + 1'b1;
        inc_click  = (r_since_click == '1) ? r_since_click : r_since_click + 1'b1;
        change_ext = CMP_W'(inc_change);
        click_ext  = CMP_W'(inc_click);
        deb_ext    = CMP_W'(i_cfg.debounce_ticks);
        win_ext    = CMP_W'(i_cfg.double_window_ticks);
        long_ext   = CMP_W'(i_cfg.long_press_ticks);
    end

    // Next state: a level change wins over a held press, which wins over a pending single.
    always_comb begin
        n_prev_level    = r_prev_level;
        n_since_change  = inc_change;
        n_since_click   = inc_click;
        n_click_pending = r_click_pending;
        n_long_done     = r_long_done;
        n_power_flag    = r_power_flag;
        gesture         = GEST_NONE;

        priority if (i_level != r_prev_level) begin
            if (!i_level && (change_ext > deb_ext)) begin
                if (click_ext < win_ext) begin
                    n_click_pending = 1'b0;
                    gesture         = GEST_DOUBLE;
                end else begin
                    n_click_pending = 1'b1;
                    n_since_click   = '0;
                end
            end
            n_since_change = '0;
            n_long_done    = 1'b0;
            n_prev_level   = i_level;
        end else if (i_level) begin
            if ((change_ext > long_ext) && !r_long_done) begin
                n_power_flag = ~r_power_flag;
                n_long_done  = 1'b1;
                gesture      = GEST_LONG;
            end
        end else begin
            if (r_click_pending && (click_ext > win_ext)) begin
                n_click_pending = 1'b0;
                gesture         = GEST_SINGLE;
            end
        end

        // The newest gesture is latched; a read reports it and then clears it.
        seen    = (gesture != GEST_NONE) ? gesture : r_latch;
        n_latch = i_read_clear ? GEST_NONE : seen;
    end

    // State update on each accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level    <= 1'b0;
            r_since_change  <= '0;
            r_since_click   <= '0;
            r_click_pending <= 1'b0;
            r_long_done     <= 1'b0;
            r_latch         <= GEST_NONE;
            r_power_flag    <= 1'b1;
        end else if (i_step) begin
            r_prev_level    <= n_prev_level;
            r_since_change  <= n_since_change;
            r_since_click   <= n_since_click;
            r_click_pending <= n_click_pending;
            r_long_done     <= n_long_done;
            r_latch         <= n_latch;
            r_power_flag    <= n_power_flag;
        end
    end

    assign o_result.gesture_now     = gesture;
    assign o_result.latched_gesture = seen;
    assign o_result.power_on        = n_power_flag;

    // The power flag moves only with a long-press event.
    `BGC_ASSERT_NEXT(a_power_only_on_long, i_clk, i_rst_n,
        !(i_step && (gesture == GEST_LONG)), $stable(r_power_flag),
        "power flag changed without a long press")
    // A long press marks the hold as done, so it cannot fire twice.
    `BGC_ASSERT_NEXT(a_long_marks_done, i_clk, i_rst_n,
        i_step && (gesture == GEST_LONG), r_long_done && r_prev_level,
        "long press did not mark the hold as done")
    // A double click never leaves a click pending.
    `BGC_ASSERT_NEXT(a_double_clears_pending, i_clk, i_rst_n,
        i_step && (gesture == GEST_DOUBLE), !r_click_pending,
        "double click left a pending click")
    // Any event shows in the latched value of the same tick.
    `BGC_ASSERT_NOW(a_event_latched, i_clk, i_rst_n,
        gesture != GEST_NONE, seen == gesture,
        "event not reported in the latched gesture")

endmodule

### rtl/button_gesture_classifier.sv
// Top level of the button gesture classifier: stream ports, configuration
// registers and output register. Depends on bgc_pkg and bgc_core.

// Each input transfer is one 1 ms tick carrying the sampled button level and a
// read-and-clear strobe; each produces exactly one result transfer with the
// gesture of that tick (none, double, long, single), the latched gesture before
// the read clears it, and the power flag. The block takes one tick per clock:
// all tick logic sits between the state registers and a single output register,
// and a new tick is accepted whenever that register is empty or being drained.
// Results appear in the cycle after their tick is accepted. The user must write the
// thresholds via the write port while no tick is in flight; the block does not check.
module button_gesture_classifier #(
    parameter int unsigned COUNT_BITS = bgc_pkg::COUNT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port
    input  logic                             i_cfg_we,
    input  logic [bgc_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [bgc_pkg::CFG_W-1:0]        i_cfg_data,
    // Tick input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [0] level, [1] read_clear
    // Result output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [1:0] gesture_now, [3:2] latched_gesture, [4] power_on
    output logic [7:0]                       m_axis_tdata
);
    import bgc_pkg::*;

    t_bgc_cfg    r_cfg;
    t_bgc_result core_result, r_out;
    logic        r_out_valid;
    logic        in_xfer;

    // A tick is taken when the output register is free or drains this cycle.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Configuration registers; an unused index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks      <= DEBOUNCE_DEF;
            r_cfg.double_window_ticks <= WINDOW_DEF;
            r_cfg.long_press_ticks    <= LONG_DEF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_DEBOUNCE: r_cfg.debounce_ticks      <= i_cfg_data;
                REG_WINDOW:   r_cfg.double_window_ticks <= i_cfg_data;
                REG_LONG:     r_cfg.long_press_ticks    <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    bgc_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (in_xfer),
        .i_level      (s_axis_tdata[0]),
        .i_read_clear (s_axis_tdata[1]),
        .i_cfg        (r_cfg),
        .o_result     (core_result)
    );

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.power_on, r_out.latched_gesture, r_out.gesture_now};

endmodule

### test/testbench.sv
// Self-checking testbench for button_gesture_classifier: drives button ticks,
// predicts each result in-line and compares every result transfer field by field.
// Depends on bgc_pkg and the button_gesture_classifier RTL.
module testbench;
    import bgc_pkg::*;

    localparam int unsigned CNT_W        = COUNT_BITS_DEF;
    localparam int unsigned LIMIT_CYCLES = 500000;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    // Read-clear strobe modes for queued ticks.
    typedef enum int {RD_NEVER, RD_ALWAYS, RD_RANDOM} t_rd_mode;

    typedef struct {
        logic level;
        logic rd;
        bit   hold;
    } t_tick;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;   // [0] level, [1] read_clear
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;        // [1:0] gesture_now, [3:2] latched, [4] power_on

    button_gesture_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    // Pending ticks, expected results and run bookkeeping.
    t_tick       tick_q[$];
    t_bgc_result gesture_q[$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned send_gap = 0;
    int unsigned sink_wait = 0;
    bit          send_calm = 1'b0;
    bit          sink_calm = 1'b0;
    bit          rush = 1'b0;

    // Predicted thresholds and classifier state.
    logic [CFG_W-1:0] debounce_cfg = DEBOUNCE_DEF;
    logic [CFG_W-1:0] window_cfg   = WINDOW_DEF;
    logic [CFG_W-1:0] long_cfg     = LONG_DEF;
    logic             held_level = 1'b0;
    logic [CNT_W-1:0] since_change = '0;
    logic [CNT_W-1:0] since_click = '0;
    logic             click_waiting = 1'b0;
    logic             long_fired = 1'b0;
    t_gesture         latched = GEST_NONE;
    logic             power_flag = 1'b1;

    // Clock and a single reset at the start.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Run time limit.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        $display("cycle %0d: %s got %0d expected %0d", cycles, field, got, want);
        mismatches++;
    endtask

    // Advances the predicted classifier by one tick and returns its result.
    task automatic advance_button(input logic lvl, input logic rd, output t_bgc_result res);
        t_gesture ev;
        ev = GEST_NONE;
        if (since_change != '1) since_change++;
        if (since_click != '1) since_click++;
        if (lvl != held_level) begin
            if (since_change > debounce_cfg && !lvl) begin
                if (since_click < window_cfg) begin
                    click_waiting = 1'b0;
                    ev = GEST_DOUBLE;
                end else begin
                    click_waiting = 1'b1;
                    since_click = '0;
                end
            end
            since_change = '0;
            long_fired = 1'b0;
            held_level = lvl;
        end else if (lvl) begin
            if (since_change > long_cfg && !long_fired) begin
                power_flag = ~power_flag;
                long_fired = 1'b1;
                ev = GEST_LONG;
            end
        end else if (click_waiting && since_click > window_cfg) begin
            click_waiting = 1'b0;
            ev = GEST_SINGLE;
        end
        if (ev != GEST_NONE) latched = ev;
        res.gesture_now = ev;
        res.latched_gesture = latched;
        res.power_on = power_flag;
        if (rd) latched = GEST_NONE;
    endtask

    // Writes one threshold register; only called while the block is idle.
    task automatic write_threshold(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        case (idx)
            REG_DEBOUNCE: debounce_cfg = val;
            REG_WINDOW:   window_cfg = val;
            REG_LONG:     long_cfg = val;
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_thresholds(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] win,
                                  input logic [CFG_W-1:0] lng);
        write_threshold(REG_DEBOUNCE, deb);
        write_threshold(REG_WINDOW, win);
        write_threshold(REG_LONG, lng);
    endtask

    task automatic add_ticks(input logic lvl, input int unsigned count, input t_rd_mode mode);
        t_tick t;
        for (int unsigned k = 0; k < count; k++) begin
            t.level = lvl;
            t.rd = (mode == RD_ALWAYS) || (mode == RD_RANDOM && $urandom_range(0, 3) == 0);
            t.hold = ($urandom_range(0, 149) == 0);
            tick_q.push_back(t);
        end
    endtask

    // A duration that lands just below, on or just above a threshold.
    function automatic int unsigned near(input logic [CFG_W-1:0] th);
        int unsigned lo;
        lo = (th > 2) ? th - 2 : 1;
        return $urandom_range(lo, th + 3);
    endfunction

    // Random gestures: mostly clean press/release pairs, some noise and bounce.
    task automatic queue_gestures(input int unsigned n);
        int unsigned start;
        int unsigned kind;
        start = tick_q.size();
        tick_q.push_back('{level: 1'b0, rd: 1'b0, hold: 1'b1});
        while (tick_q.size() - start < n) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                add_ticks(1'b1, $urandom_range(0, 1) ? near(debounce_cfg) : near(long_cfg),
                          RD_RANDOM);
                add_ticks(1'b0, $urandom_range(0, 1) ? near(window_cfg) : $urandom_range(1, 3),
                          RD_RANDOM);
            end else if (kind < 9) begin
                for (int k = 0; k < 6; k++) add_ticks(1'($urandom_range(0, 1)), 1, RD_RANDOM);
            end else begin
                for (int k = 0; k < 4; k++) add_ticks(k[0], 1, RD_RANDOM);
            end
        end
    endtask

    // Waits until every tick has been sent and every result checked.
    task automatic wait_idle();
        while (tick_q.size() != 0 || s_tvalid || gesture_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Tick driver: predicts on each accepted transfer, then presents the next tick.
    always @(posedge i_clk) begin : drive_ticks
        t_tick       nxt;
        t_bgc_result want;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_button(s_tdata[0], s_tdata[1], want);
                gesture_q.push_back(want);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (tick_q.size() != 0 && !(tick_q[0].hold && gesture_q.size() != 0)) begin
                    nxt = tick_q.pop_front();
                    s_tdata <= {6'b0, nxt.rd, nxt.level};
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
                    send_gap = (rush || send_calm) ? 0 : $urandom_range(0, 12);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random back-pressure and field-by-field comparison.
    always @(posedge i_clk) begin : check_results
        t_bgc_result want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (gesture_q.size() == 0) begin
                    report_mismatch("result with nothing expected, data", m_tdata, 0);
                end else begin
                    want = gesture_q.pop_front();
                    if (m_tdata[1:0] !== want.gesture_now)
                        report_mismatch("gesture_now", m_tdata[1:0], want.gesture_now);
                    if (m_tdata[3:2] !== want.latched_gesture)
                        report_mismatch("latched_gesture", m_tdata[3:2], want.latched_gesture);
                    if (m_tdata[4] !== want.power_on)
                        report_mismatch("power_on", m_tdata[4], want.power_on);
                    if (m_tdata[7:5] !== 3'b000)
                        report_mismatch("tdata padding", m_tdata[7:5], 0);
                end
                if ($urandom_range(0, 29) == 0) sink_calm = !sink_calm;
                sink_wait = (rush || sink_calm) ? 0 : $urandom_range(0, 12);
            end else if (sink_wait > 0) begin
                sink_wait--;
            end
            m_tready <= (sink_wait == 0);
        end
    end

    // Stimulus sequence, phase by phase.
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset thresholds: a click soon after reset is a double click.
        add_ticks(1'b1, 60, RD_NEVER);
        add_ticks(1'b0, 1, RD_NEVER);
        add_ticks(1'b0, 3, RD_RANDOM);
        wait_idle();

        // Directed gestures with small thresholds; the out-of-range index is ignored.
        set_thresholds(16'd2, 16'd6, 16'd5);
        write_threshold(REG_UNUSED, 16'hFFFF);
        add_ticks(1'b1, 3, RD_NEVER);
        add_ticks(1'b0, 1, RD_ALWAYS);
        add_ticks(1'b0, 7, RD_NEVER);     // pending click turns into a single
        add_ticks(1'b0, 1, RD_ALWAYS);
        add_ticks(1'b1, 6, RD_NEVER);
        add_ticks(1'b1, 1, RD_ALWAYS);    // long press read in the same tick
        add_ticks(1'b1, 2, RD_NEVER);     // no second long press in the same hold
        add_ticks(1'b0, 1, RD_NEVER);
        add_ticks(1'b1, 3, RD_NEVER);
        add_ticks(1'b0, 1, RD_NEVER);     // quick second click gives a double
        add_ticks(1'b1, 1, RD_NEVER);
        add_ticks(1'b0, 1, RD_NEVER);     // bounce shorter than debounce
        add_ticks(1'b0, 2, RD_ALWAYS);
        wait_idle();

        // Thresholds at the top of the range do not fire within a short hold.
        set_thresholds(16'd65534, 16'd65535, 16'd65535);
        rush = 1'b1;
        add_ticks(1'b1, 20, RD_NEVER);
        add_ticks(1'b0, 10, RD_RANDOM);
        add_ticks(1'b1, 2, RD_NEVER);
        add_ticks(1'b0, 3, RD_ALWAYS);
        wait_idle();
        rush = 1'b0;

        // Zero thresholds.
        set_thresholds(16'd0, 16'd0, 16'd0);
        queue_gestures(60);
        wait_idle();

        // Random thresholds and gestures.
        for (int ph = 0; ph < 5; ph++) begin
            set_thresholds(16'($urandom_range(0, 6)), 16'($urandom_range(0, 24)),
                           16'($urandom_range(1, 30)));
            queue_gestures(80);
            wait_idle();
        end

        repeat (5) @(posedge i_clk);
        if (mismatches == 0 && gesture_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/bgc_pkg.sv
rtl/bgc_core.sv
rtl/button_gesture_classifier.sv
test/testbench.sv
